FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/pcs_pkg.sv
// types and constants of the plotter command scanner
// no dependencies
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int COORD_W    = 32;
  localparam int OUT_W      = 32;
  localparam int LINE_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'd1;

  localparam logic signed [COORD_W-1:0] START_X_RESET = COORD_W'(421);
  localparam logic signed [COORD_W-1:0] START_Y_RESET = COORD_W'(298);

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_UNFIN = 2'd2;
  localparam logic [1:0] KIND_CLEAN = 2'd3;

  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_Y    = 8'h79;
  localparam logic [7:0] CH_EQ   = 8'h3d;
  localparam logic [7:0] CH_MIN  = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_O    = 8'h6f;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [OUT_W-1:0] pos_x_out;
    logic signed [OUT_W-1:0] pos_y_out;
    logic [LINE_W-1:0]       line_out;
  } out_item_t;

endpackage

FILE: hdl/plotter_command_scanner.sv
// Plotter command scanner: takes one character per transaction and recognizes
// "dx=<n>", "dy=<n>" and "go" statements, each closed by a newline. A go
// moves the pen by the current steps and returns the new position; an illegal
// character returns an error with its line number and the block then ignores
// all further input until reset; end of input returns an unfinished or clean
// end result and also halts. One character is accepted every cycle while in_stall is low;
// a result passes through the input register, then the result register. in_stall rises
// only while the result register holds an untaken result and the next character would
// produce another one. Writing start_x or start_y loads the pen position at once; write
// only while idle.
// depends on pcs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plotter_command_scanner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pcs_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pcs_pkg::out_item_t               out_data
);
  import pcs_pkg::*;

  localparam logic [3:0] ST_START  = 4'd0;
  localparam logic [3:0] ST_D      = 4'd1;
  localparam logic [3:0] ST_DXY    = 4'd2;
  localparam logic [3:0] ST_EQ     = 4'd3;
  localparam logic [3:0] ST_MINUS  = 4'd4;
  localparam logic [3:0] ST_DIGITS = 4'd5;
  localparam logic [3:0] ST_G      = 4'd6;
  localparam logic [3:0] ST_GO     = 4'd7;

  localparam int ACC_EXT_W = COORD_W + 4;
  localparam logic [COORD_W-1:0] CSIGN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [LINE_W-1:0]  LINE_MAX = '1;

  logic                s1_valid;
  in_item_t            s1_data;
  logic                s1_adv;

  logic [3:0]          state, state_next;
  logic [COORD_W-1:0]  pen_x, pen_x_next;
  logic [COORD_W-1:0]  pen_y, pen_y_next;
  logic [COORD_W-1:0]  step_x, step_x_next;
  logic [COORD_W-1:0]  step_y, step_y_next;
  logic [COORD_W-1:0]  number_acc, number_acc_next;
  logic                number_negative, number_negative_next;
  logic                target_is_y, target_is_y_next;
  logic [LINE_W-1:0]   line_count, line_count_next;
  logic                halted, halted_next;

  logic                emit;
  logic [1:0]          kind;
  logic                err;
  logic [7:0]          c;
  logic                is_digit;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [ACC_EXT_W-1:0] acc_mac;
  logic [COORD_W-1:0]  step_val;

  assign c        = s1_data.char_in;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign acc_ext  = ACC_EXT_W'(number_acc);
  assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_W'(c[3:0]);
  assign step_val = number_negative ? (COORD_W'(0) - number_acc) :
                    ((number_acc >= CSIGN) ? (CSIGN - COORD_W'(1)) : number_acc);

  always_comb begin
    state_next           = state;
    pen_x_next           = pen_x;
    pen_y_next           = pen_y;
    step_x_next          = step_x;
    step_y_next          = step_y;
    number_acc_next      = number_acc;
    number_negative_next = number_negative;
    target_is_y_next     = target_is_y;
    line_count_next      = line_count;
    halted_next          = halted;
    emit                 = 1'b0;
    kind                 = KIND_MOVE;
    err                  = 1'b0;
    if (s1_valid && !halted) begin
      if (s1_data.end_of_input) begin
        halted_next = 1'b1;
        emit        = 1'b1;
        kind        = (state != ST_START) ? KIND_UNFIN : KIND_CLEAN;
      end else begin
        case (state)
          ST_START: begin
            if (c == CH_D) state_next = ST_D;
            else if (c == CH_G) state_next = ST_G;
            else err = 1'b1;
          end
          ST_D: begin
            if (c == CH_X || c == CH_Y) begin
              target_is_y_next = (c == CH_Y);
              state_next       = ST_DXY;
            end else err = 1'b1;
          end
          ST_DXY: begin
            if (c == CH_EQ) begin
              number_acc_next      = '0;
              number_negative_next = 1'b0;
              state_next           = ST_EQ;
            end else err = 1'b1;
          end
          ST_EQ, ST_MINUS, ST_DIGITS: begin
            if (is_digit) begin
              if (acc_mac > ACC_EXT_W'(CSIGN)) number_acc_next = CSIGN;
              else number_acc_next = acc_mac[COORD_W-1:0];
              state_next = ST_DIGITS;
            end else if (state == ST_EQ && c == CH_MIN) begin
              number_negative_next = 1'b1;
              state_next           = ST_MINUS;
            end else if (state == ST_DIGITS && c == CH_NL) begin
              if (target_is_y) step_y_next = step_val;
              else step_x_next = step_val;
              state_next = ST_START;
            end else err = 1'b1;
          end
          ST_G: begin
            if (c == CH_O) state_next = ST_GO;
            else err = 1'b1;
          end
          ST_GO: begin
            if (c == CH_NL) begin
              pen_x_next = pen_x + step_x;
              pen_y_next = pen_y + step_y;
              emit       = 1'b1;
              kind       = KIND_MOVE;
              state_next = ST_START;
            end else err = 1'b1;
          end
          default: err = 1'b1;
        endcase
        if (err) begin
          state_next  = state;
          halted_next = 1'b1;
          emit        = 1'b1;
          kind        = KIND_ERROR;
        end else if (c == CH_NL && line_count != LINE_MAX) begin
          line_count_next = line_count + LINE_W'(1);
        end
      end
    end
  end

  assign s1_adv   = s1_valid && (!out_valid || !out_stall || !emit);
  assign in_stall = s1_valid && !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_START;
      pen_x           <= START_X_RESET;
      pen_y           <= START_Y_RESET;
      step_x          <= '0;
      step_y          <= '0;
      number_acc      <= '0;
      number_negative <= 1'b0;
      target_is_y     <= 1'b0;
      line_count      <= LINE_W'(1);
      halted          <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_START_X) pen_x <= COORD_W'(signed'(cfg_data));
      if (cfg_index == REG_START_Y) pen_y <= COORD_W'(signed'(cfg_data));
    end else if (s1_adv) begin
      state           <= state_next;
      pen_x           <= pen_x_next;
      pen_y           <= pen_y_next;
      step_x          <= step_x_next;
      step_y          <= step_y_next;
      number_acc      <= number_acc_next;
      number_negative <= number_negative_next;
      target_is_y     <= target_is_y_next;
      line_count      <= line_count_next;
      halted          <= halted_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && emit) begin
      out_data.kind      <= kind;
      out_data.pos_x_out <= OUT_W'(signed'(pen_x_next));
      out_data.pos_y_out <= OUT_W'(signed'(pen_y_next));
      out_data.line_out  <= line_count;
    end
  end

  `ASSERT_NEXT(a_halt_sticky, clk, rst, halted && !cfg_write, halted)
  `ASSERT_IMPL(a_nonmove_halted, clk, rst, out_valid && out_data.kind != KIND_MOVE, halted)
  `ASSERT_NEXT(a_go_emits, clk, rst, s1_adv && !halted && state == ST_GO && !s1_data.end_of_input && c == CH_NL, out_valid && out_data.kind == KIND_MOVE)
  `ASSERT_IMPL(a_stall_needs_item, clk, rst, in_stall, s1_valid && out_valid)

endmodule

FILE: bench/plotter_command_scanner_checker.sv
// checker for the plotter command scanner: watches the config port and both channels,
// predicts the move, error and end reports and compares them field by field
// depends on pcs_pkg
`timescale 1ns / 1ps
module plotter_command_scanner_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  pcs_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  pcs_pkg::out_item_t             out_data,
  output int                             fails,
  output int                             pending
);
  import pcs_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_D, SC_DXY, SC_EQ, SC_MINUS, SC_DIGITS, SC_G, SC_GO
  } scan_state_t;

  scan_state_t        scan;
  logic signed [31:0] pen_x, pen_y, step_x, step_y;
  logic [31:0]        magnitude;
  logic [31:0]        line_no;
  logic               negative, to_y, halted;
  out_item_t          report_q[$];

  function automatic out_item_t pen_report(logic [1:0] k);
    out_item_t r;
    r.kind = k;
    r.pos_x_out = pen_x;
    r.pos_y_out = pen_y;
    r.line_out = line_no;
    return r;
  endfunction

  task automatic scan_char(input in_item_t t, output bit has, output out_item_t rep);
    logic [7:0]  c;
    logic [63:0] digit;
    logic [31:0] val;
    bit          bad, digit_ok;
    c = t.char_in;
    digit = 64'(c - CH_ZERO);
    digit_ok = (c >= CH_ZERO) && (c <= CH_NINE);
    bad = 1'b0;
    has = 1'b0;
    rep = '0;
    if (halted) begin
      has = 1'b0;
    end else if (t.end_of_input) begin
      halted = 1'b1;
      has = 1'b1;
      rep = pen_report((scan == SC_IDLE) ? KIND_CLEAN : KIND_UNFIN);
    end else begin
      case (scan)
        SC_IDLE: begin
          if (c == CH_D) scan = SC_D;
          else if (c == CH_G) scan = SC_G;
          else bad = 1'b1;
        end
        SC_D: begin
          if (c == CH_X || c == CH_Y) begin
            to_y = (c == CH_Y);
            scan = SC_DXY;
          end else bad = 1'b1;
        end
        SC_DXY: begin
          if (c == CH_EQ) begin
            magnitude = '0;
            negative = 1'b0;
            scan = SC_EQ;
          end else bad = 1'b1;
        end
        SC_EQ, SC_MINUS, SC_DIGITS: begin
          if (digit_ok) begin
            // magnitude saturates at 2^31
            if (64'(magnitude) > (64'h8000_0000 - digit) / 10) magnitude = 32'h8000_0000;
            else magnitude = magnitude * 10 + 32'(digit);
            scan = SC_DIGITS;
          end else if (scan == SC_EQ && c == CH_MIN) begin
            negative = 1'b1;
            scan = SC_MINUS;
          end else if (scan == SC_DIGITS && c == CH_NL) begin
            if (negative) val = -magnitude;
            else if (magnitude >= 32'h8000_0000) val = 32'h7fff_ffff;
            else val = magnitude;
            if (to_y) step_y = val;
            else step_x = val;
            scan = SC_IDLE;
          end else bad = 1'b1;
        end
        SC_G: begin
          if (c == CH_O) scan = SC_GO;
          else bad = 1'b1;
        end
        SC_GO: begin
          if (c == CH_NL) begin
            pen_x = pen_x + step_x;
            pen_y = pen_y + step_y;
            has = 1'b1;
            rep = pen_report(KIND_MOVE);
            scan = SC_IDLE;
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        halted = 1'b1;
        has = 1'b1;
        rep = pen_report(KIND_ERROR);
      end else if (c == CH_NL && line_no != '1) begin
        line_no = line_no + 1;
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $error("%s expected 0x%08h got 0x%08h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    bit        has;
    out_item_t rep, want;
    if (rst) begin
      scan = SC_IDLE;
      pen_x = START_X_RESET;
      pen_y = START_Y_RESET;
      step_x = '0;
      step_y = '0;
      magnitude = '0;
      negative = 1'b0;
      to_y = 1'b0;
      line_no = 32'd1;
      halted = 1'b0;
      report_q.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          fails++;
          $error("transaction with nothing expected, kind %0d", out_data.kind);
        end else begin
          want = report_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data.kind));
          check_field("pos_x_out", want.pos_x_out, out_data.pos_x_out);
          check_field("pos_y_out", want.pos_y_out, out_data.pos_y_out);
          check_field("line_out", want.line_out, out_data.line_out);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_START_X: pen_x = cfg_data;
          REG_START_Y: pen_y = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        scan_char(in_data, has, rep);
        if (has) report_q.push_back(rep);
      end
    end
    pending = report_q.size();
  end

endmodule

FILE: bench/plotter_command_scanner_test.sv
// top of the plotter command scanner bench: clock, reset, config writes and statement stimulus
// with random idling on both channels; depends on pcs_pkg, the scanner and its checker
`timescale 1ns / 1ps
module plotter_command_scanner_test;
  import pcs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  int                    fails, pending;
  int                    busy_pct = 0;
  int                    chars_sent = 0;
  int                    cycles = 0;
  string                 prefixes[8] = '{"", "d", "dx", "dy=", "dx=-", "dy=12", "g", "go"};
  string                 misplaced[9] = '{"\n", "dx=\n", "dy=-\n", "dd", "gx", "dx=5-", "goo",
                                          "dz", "dx=-\n"};
  int                    phase_busy[6] = '{0, 25, 60, 10, 40, 0};

  always #5 clk = ~clk;

  plotter_command_scanner u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  plotter_command_scanner_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fails(fails), .pending(pending)
  );

  function automatic int idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(logic [7:0] c, logic eoi);
    in_item_t t;
    t.char_in = c;
    t.end_of_input = eoi;
    if ($urandom_range(0, 99) < busy_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic string number_text();
    string       s;
    bit [31:0]   r;
    int          v;
    r = $urandom();
    v = $urandom_range(0, 199998) - 99999;
    case ($urandom_range(0, 11))
      0: s = "2147483647";
      1: s = "2147483648";
      2: s = "-2147483648";
      3: s = "-2147483649";
      4: s = "-0";
      5: s = {"000", $sformatf("%0d", r % 100)};
      6: begin
        s = $sformatf("%0d", r);
        repeat ($urandom_range(1, 10)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
      7: s = $sformatf("-%0d", r);
      8, 9: s = $sformatf("%0d", $urandom_range(0, 9));
      default: s = $sformatf("%0d", v);
    endcase
    return s;
  endfunction

  task automatic send_statement();
    string axis;
    axis = $urandom_range(0, 1) ? "y" : "x";
    if ($urandom_range(0, 9) < 4) send_text("go\n");
    else send_text({"d", axis, "=", number_text(), "\n"});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(logic [31:0] x, logic [31:0] y);
    cfg_write <= 1'b1;
    cfg_index <= REG_START_X;
    cfg_data <= x;
    @(negedge clk);
    cfg_index <= REG_START_Y;
    cfg_data <= y;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("plotter_command_scanner test failed");
    $finish;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : sink
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if ($urandom_range(0, 99) < busy_pct) hold = idle_len();
      out_stall <= (hold > 0);
    end
  end

  initial begin : stimulus
    logic [7:0] junk;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle moves, negative zero, digit nine
    send_text("go\ndx=-0\ndy=9\ngo\n");

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        1: write_start(32'h7fff_ffff, 32'h8000_0000);
        2: write_start(32'h8000_0000, 32'h7fff_ffff);
        3: write_start(32'h0000_0000, 32'hffff_ffff);
        4, 5: write_start($urandom(), $urandom());
        default: ;
      endcase
      busy_pct = phase_busy[phase];
      while (chars_sent < 17 + (phase + 1) * 135) send_statement();
    end

    // the block halts here until reset
    busy_pct = 20;
    case ($urandom_range(0, 3))
      0: send_item(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_text(prefixes[$urandom_range(1, 7)]);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send_text(prefixes[$urandom_range(0, 7)]);
        do junk = 8'($urandom_range(0, 255));
        while (junk == CH_D || junk == CH_G || junk == CH_X || junk == CH_Y ||
               junk == CH_EQ || junk == CH_MIN || junk == CH_NL || junk == CH_O ||
               (junk >= CH_ZERO && junk <= CH_NINE));
        send_item(junk, 1'b0);
      end
      default: send_text(misplaced[$urandom_range(0, 8)]);
    endcase

    // ignored while halted
    repeat (40) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (fails == 0) $display("plotter_command_scanner test passed");
    else $display("plotter_command_scanner test failed");
    $finish;
  end

endmodule
